// ===== hw/rtl/tlsp_pkg.sv =====
package tlsp_pkg;

  // tick counter width and pattern limits, in 10 ms ticks
  localparam int unsigned CountWidth = 8;
  localparam logic [CountWidth-1:0] FLICK_TICKS = 8'd25;
  localparam logic [CountWidth-1:0] LONG_TICKS  = 8'd50;
  localparam logic [CountWidth-1:0] OFF_TICKS   = 8'd100;
  localparam logic [CountWidth-1:0] HALF_FAST   = 8'd25;
  localparam logic [CountWidth-1:0] HALF_MID    = 8'd50;
  localparam logic [CountWidth-1:0] HALF_SLOW   = 8'd100;
  localparam logic [CountWidth-1:0] WRAP_FAST   = 8'd50;
  localparam logic [CountWidth-1:0] WRAP_MID    = 8'd100;
  localparam logic [CountWidth-1:0] WRAP_SLOW   = 8'd200;
  localparam logic [CountWidth-1:0] PRESET_ANTI = 8'd25;

  // action codes
  localparam logic ACT_POLL   = 1'b0;
  localparam logic ACT_STATUS = 1'b1;

  // module status codes
  typedef enum logic [3:0] {
    ST_OFF        = 4'd0,
    ST_UNINIT     = 4'd1,
    ST_SETUP      = 4'd2,
    ST_NORMAL_A   = 4'd3,
    ST_NORMAL_B   = 4'd4,
    ST_NORMAL_C   = 4'd5,
    ST_NORMAL_D   = 4'd6,
    ST_NORMAL_E   = 4'd7,
    ST_RESET_WARN = 4'd8,
    ST_RECEIVED   = 4'd9,
    ST_ACTED      = 4'd10,
    ST_FAULT_A    = 4'd11,
    ST_FAULT_B    = 4'd12
  } status_t;

  // led pattern modes
  typedef enum logic [3:0] {
    MODE_ON        = 4'd0,
    MODE_OFF       = 4'd1,
    MODE_FLASH25   = 4'd2,
    MODE_FLASH50   = 4'd3,
    MODE_FLASH100  = 4'd4,
    MODE_FLICK_ON  = 4'd5,
    MODE_FLICK_OFF = 4'd6,
    MODE_LONG_ON   = 4'd7,
    MODE_LONG_OFF  = 4'd8,
    MODE_OFF100    = 4'd9
  } led_mode_t;

  // input beat
  typedef struct packed {
    logic       action;
    logic       tick;
    logic [3:0] status;
  } cmd_t;

  // result beat
  typedef struct packed {
    logic green_on;
    logic yellow_on;
  } led_t;

  // per-led update request from the status decoder
  typedef struct packed {
    logic                  load_mode;
    led_mode_t             mode;
    logic                  load_count;
    logic [CountWidth-1:0] count;
  } led_cmd_t;

endpackage

// ===== hw/rtl/tlsp_status_decode.sv =====
module tlsp_status_decode
  import tlsp_pkg::*;
(
  input  logic [3:0] status,
  output led_cmd_t   green_cmd,
  output led_cmd_t   yellow_cmd
);

  // map a module status to a mode pair and optional counter presets
  always_comb begin
    green_cmd  = '{load_mode: 1'b0, mode: MODE_OFF, load_count: 1'b0, count: '0};
    yellow_cmd = '{load_mode: 1'b0, mode: MODE_OFF, load_count: 1'b0, count: '0};
    unique case (status)
      ST_OFF: begin
        green_cmd.load_mode  = 1'b1;
        yellow_cmd.load_mode = 1'b1;
      end
      ST_UNINIT: begin
        green_cmd.load_mode  = 1'b1;
        green_cmd.mode       = MODE_ON;
        yellow_cmd.load_mode = 1'b1;
      end
      ST_SETUP: begin
        green_cmd.load_mode  = 1'b1;
        yellow_cmd.load_mode = 1'b1;
        yellow_cmd.mode      = MODE_FLASH50;
      end
      ST_NORMAL_A, ST_NORMAL_B, ST_NORMAL_C, ST_NORMAL_D, ST_NORMAL_E: begin
        green_cmd.load_mode  = 1'b1;
        yellow_cmd.load_mode = 1'b1;
        yellow_cmd.mode      = MODE_ON;
      end
      ST_RESET_WARN: begin
        // green starts half a period ahead so the two alternate
        green_cmd.load_mode   = 1'b1;
        green_cmd.mode        = MODE_FLASH25;
        green_cmd.load_count  = 1'b1;
        green_cmd.count       = PRESET_ANTI;
        yellow_cmd.load_mode  = 1'b1;
        yellow_cmd.mode       = MODE_FLASH25;
        yellow_cmd.load_count = 1'b1;
      end
      ST_RECEIVED: begin
        green_cmd.load_mode  = 1'b1;
        green_cmd.mode       = MODE_FLICK_ON;
        yellow_cmd.load_mode = 1'b1;
        yellow_cmd.mode      = MODE_ON;
      end
      ST_ACTED: begin
        green_cmd.load_mode  = 1'b1;
        green_cmd.mode       = MODE_LONG_ON;
        yellow_cmd.load_mode = 1'b1;
        yellow_cmd.mode      = MODE_ON;
      end
      ST_FAULT_A, ST_FAULT_B: begin
        green_cmd.load_mode   = 1'b1;
        green_cmd.mode        = MODE_FLASH25;
        green_cmd.load_count  = 1'b1;
        yellow_cmd.load_mode  = 1'b1;
        yellow_cmd.mode       = MODE_FLASH25;
        yellow_cmd.load_count = 1'b1;
      end
      default: begin
        // unused status codes leave both leds alone
      end
    endcase
  end

endmodule

// ===== hw/rtl/tlsp_led_channel.sv =====
module tlsp_led_channel
  import tlsp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     action,
  input  logic     tick,
  input  led_cmd_t cmd,
  output logic     level
);

  led_mode_t             mode;
  led_mode_t             mode_next;
  logic [CountWidth-1:0] count;
  logic [CountWidth-1:0] count_next;
  logic [CountWidth-1:0] count_adv;
  logic                  level_next;

  // tick advances the counter before the mode is evaluated
  assign count_adv = tick ? count + 1'b1 : count;

  // pattern evaluation on poll, mode and preset load on status
  always_comb begin
    mode_next  = mode;
    count_next = count;
    level_next = level;
    if (action == ACT_STATUS) begin
      if (cmd.load_mode) begin
        mode_next = cmd.mode;
      end
      if (cmd.load_count) begin
        count_next = cmd.count;
      end
    end else begin
      count_next = count_adv;
      unique case (mode)
        MODE_ON: begin
          level_next = 1'b1;
          count_next = '0;
        end
        MODE_OFF: begin
          level_next = 1'b0;
          count_next = '0;
        end
        MODE_FLASH25: begin
          level_next = (count_adv >= HALF_FAST);
          if (count_adv >= WRAP_FAST) count_next = '0;
        end
        MODE_FLASH50: begin
          level_next = (count_adv >= HALF_MID);
          if (count_adv >= WRAP_MID) count_next = '0;
        end
        MODE_FLASH100: begin
          level_next = (count_adv >= HALF_SLOW);
          if (count_adv >= WRAP_SLOW) count_next = '0;
        end
        MODE_FLICK_ON: begin
          level_next = 1'b1;
          if (count_adv >= FLICK_TICKS) begin
            count_next = '0;
            mode_next  = MODE_OFF;
          end
        end
        MODE_FLICK_OFF: begin
          level_next = 1'b0;
          if (count_adv >= FLICK_TICKS) begin
            count_next = '0;
            mode_next  = MODE_ON;
          end
        end
        MODE_LONG_ON: begin
          level_next = 1'b1;
          if (count_adv >= LONG_TICKS) begin
            count_next = '0;
            mode_next  = MODE_OFF;
          end
        end
        MODE_LONG_OFF: begin
          level_next = 1'b0;
          if (count_adv >= LONG_TICKS) begin
            count_next = '0;
            mode_next  = MODE_ON;
          end
        end
        MODE_OFF100: begin
          level_next = 1'b0;
          if (count_adv >= OFF_TICKS) begin
            count_next = '0;
            mode_next  = MODE_ON;
          end
        end
        default: begin
          // unreachable codes hold everything except the counter advance
        end
      endcase
    end
  end

  // led state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_OFF;
      count <= '0;
      level <= 1'b0;
    end else if (en) begin
      mode  <= mode_next;
      count <= count_next;
      level <= level_next;
    end
  end

endmodule

// ===== hw/rtl/two_led_status_pattern_driver.sv =====
// Status LED driver for a green and a yellow LED. Each cmd beat is either a
// poll (action 0, with tick set when 10 ms have passed) or a module status
// update (action 1); every cmd beat yields exactly one led beat carrying the
// drive levels after that beat took effect. A beat is registered on entry,
// evaluated from the input register and lands in the led level registers,
// which form the output register; a new beat is taken every cycle as long as
// the output register is drained, and the led state update is the loop that
// sets this rate.
module two_led_status_pattern_driver
  import tlsp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic led_valid,
  input  logic led_ready,
  output led_t led
);

  logic     hold_valid;
  cmd_t     hold;
  logic     advance;
  led_cmd_t green_cmd;
  led_cmd_t yellow_cmd;
  logic     green_level;
  logic     yellow_level;
  logic     green_level_now;
  logic     yellow_level_now;

  // evaluate the held beat when the output register can take its result
  assign advance   = hold_valid && (!led_valid || led_ready);
  assign cmd_ready = !hold_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (cmd_ready) begin
      hold_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ready && cmd_valid) begin
      hold <= cmd;
    end
  end

  // status to mode mapping
  tlsp_status_decode u_decode (
    .status     (hold.status),
    .green_cmd  (green_cmd),
    .yellow_cmd (yellow_cmd)
  );

  // one pattern engine per led
  tlsp_led_channel u_green (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .action (hold.action),
    .tick   (hold.tick),
    .cmd    (green_cmd),
    .level  (green_level)
  );

  tlsp_led_channel u_yellow (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .action (hold.action),
    .tick   (hold.tick),
    .cmd    (yellow_cmd),
    .level  (yellow_level)
  );

  assign green_level_now  = green_level;
  assign yellow_level_now = yellow_level;

  // output register, valid tracks pending result beats
  always_ff @(posedge clk) begin
    if (rst) begin
      led_valid <= 1'b0;
    end else if (advance) begin
      led_valid <= 1'b1;
    end else if (led_ready) begin
      led_valid <= 1'b0;
    end
  end

  // the channel level registers hold the levels of the pending result beat
  always_comb begin
    led.green_on  = green_level_now;
    led.yellow_on = yellow_level_now;
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import tlsp_pkg::*;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic led_valid;
  logic led_ready;
  led_t led;

  two_led_status_pattern_driver u_dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .led_valid(led_valid),
    .led_ready(led_ready),
    .led      (led)
  );

  // predicted led state, index 0 green, index 1 yellow
  led_mode_t   pred_mode[2];
  logic [7:0]  pred_count[2];
  logic        pred_level[2];

  led_t        levels_q[$];
  int unsigned err_count;
  int unsigned beats_sent;
  bit          quiet;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  // idle length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic cmd_t make_cmd(input logic act, input logic tk, input logic [3:0] st);
    cmd_t c;
    c.action = act;
    c.tick   = tk;
    c.status = st;
    return c;
  endfunction

  // predictor: flash pattern, lit from half period up to and including wrap
  function automatic void flash_led(input int i, input logic [7:0] half,
                                    input logic [7:0] wrap);
    pred_level[i] = (pred_count[i] >= half);
    if (pred_count[i] >= wrap) pred_count[i] = '0;
  endfunction

  // predictor: fixed level until the limit, then move to the next mode
  function automatic void timed_led(input int i, input logic lvl, input logic [7:0] limit,
                                    input led_mode_t nxt);
    pred_level[i] = lvl;
    if (pred_count[i] >= limit) begin
      pred_count[i] = '0;
      pred_mode[i]  = nxt;
    end
  endfunction

  function automatic void eval_led(input int i);
    case (pred_mode[i])
      MODE_ON: begin
        pred_level[i] = 1'b1;
        pred_count[i] = '0;
      end
      MODE_OFF: begin
        pred_level[i] = 1'b0;
        pred_count[i] = '0;
      end
      MODE_FLASH25:   flash_led(i, HALF_FAST, WRAP_FAST);
      MODE_FLASH50:   flash_led(i, HALF_MID, WRAP_MID);
      MODE_FLASH100:  flash_led(i, HALF_SLOW, WRAP_SLOW);
      MODE_FLICK_ON:  timed_led(i, 1'b1, FLICK_TICKS, MODE_OFF);
      MODE_FLICK_OFF: timed_led(i, 1'b0, FLICK_TICKS, MODE_ON);
      MODE_LONG_ON:   timed_led(i, 1'b1, LONG_TICKS, MODE_OFF);
      MODE_LONG_OFF:  timed_led(i, 1'b0, LONG_TICKS, MODE_ON);
      MODE_OFF100:    timed_led(i, 1'b0, OFF_TICKS, MODE_ON);
      default: ;
    endcase
  endfunction

  function automatic void apply_status(input logic [3:0] st);
    case (st)
      ST_OFF: begin
        pred_mode[0] = MODE_OFF;
        pred_mode[1] = MODE_OFF;
      end
      ST_UNINIT: begin
        pred_mode[0] = MODE_ON;
        pred_mode[1] = MODE_OFF;
      end
      ST_SETUP: begin
        pred_mode[0] = MODE_OFF;
        pred_mode[1] = MODE_FLASH50;
      end
      ST_NORMAL_A, ST_NORMAL_B, ST_NORMAL_C, ST_NORMAL_D, ST_NORMAL_E: begin
        pred_mode[0] = MODE_OFF;
        pred_mode[1] = MODE_ON;
      end
      ST_RESET_WARN: begin
        // green preset half a period ahead, so the two flash in antiphase
        pred_count[0] = PRESET_ANTI;
        pred_count[1] = '0;
        pred_mode[0]  = MODE_FLASH25;
        pred_mode[1]  = MODE_FLASH25;
      end
      ST_RECEIVED: begin
        pred_mode[0] = MODE_FLICK_ON;
        pred_mode[1] = MODE_ON;
      end
      ST_ACTED: begin
        pred_mode[0] = MODE_LONG_ON;
        pred_mode[1] = MODE_ON;
      end
      ST_FAULT_A, ST_FAULT_B: begin
        pred_count[0] = '0;
        pred_count[1] = '0;
        pred_mode[0]  = MODE_FLASH25;
        pred_mode[1]  = MODE_FLASH25;
      end
      default: ;
    endcase
  endfunction

  // levels after one cmd beat
  function automatic led_t led_predict(input cmd_t c);
    led_t r;
    if (c.action == ACT_POLL) begin
      if (c.tick) begin
        pred_count[0] = pred_count[0] + 8'd1;
        pred_count[1] = pred_count[1] + 8'd1;
      end
      eval_led(1);
      eval_led(0);
    end else begin
      apply_status(c.status);
    end
    r.green_on  = pred_level[0];
    r.yellow_on = pred_level[1];
    return r;
  endfunction

  // send one cmd beat and record its expected levels
  task automatic send_cmd(input cmd_t c);
    int g;
    @(negedge clk);
    cmd_valid = 1'b1;
    cmd       = c;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    levels_q.push_back(led_predict(c));
    beats_sent++;
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk);
      cmd_valid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic drop_cmd();
    @(negedge clk);
    cmd_valid = 1'b0;
  endtask

  task automatic wait_drained(input int limit);
    int n;
    n = 0;
    while (levels_q.size() != 0 && n < limit) begin
      @(posedge clk);
      n++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    led_t want;
    if (!rst && led_valid && led_ready) begin
      if (levels_q.size() == 0) begin
        report_mismatch($sformatf("led beat %b with nothing expected", led));
      end else begin
        want = levels_q.pop_front();
        if (led.green_on !== want.green_on)
          report_mismatch($sformatf("green_on %b, expected %b", led.green_on, want.green_on));
        if (led.yellow_on !== want.yellow_on)
          report_mismatch($sformatf("yellow_on %b, expected %b", led.yellow_on,
                                    want.yellow_on));
      end
    end
  end

  // receiver stalls
  initial begin
    int run;
    int g;
    led_ready = 1'b1;
    forever begin
      run = $urandom_range(1, 16);
      repeat (run) @(negedge clk);
      g = pick_gap();
      if (g > 0) begin
        led_ready = 1'b0;
        repeat (g) @(negedge clk);
        led_ready = 1'b1;
      end
    end
  end

  // polls out of reset, then every status code including the ignored ones
  task automatic test_directed();
    send_cmd(make_cmd(ACT_POLL, 1'b0, 4'd0));
    send_cmd(make_cmd(ACT_POLL, 1'b1, 4'd15));
    for (int s = 0; s < 16; s++) begin
      send_cmd(make_cmd(ACT_STATUS, s[0], s[3:0]));
      if (s[0]) send_cmd(make_cmd(ACT_POLL, 1'b1, ~s[3:0]));
    end
  endtask

  // status followed by a run of polls, with an occasional random status mixed in
  task automatic run_pattern(input logic [3:0] st, input int len);
    send_cmd(make_cmd(ACT_STATUS, 1'($urandom_range(0, 1)), st));
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < 4)
        send_cmd(make_cmd(ACT_STATUS, 1'($urandom_range(0, 1)),
                          4'($urandom_range(0, 15))));
      else
        send_cmd(make_cmd(ACT_POLL, $urandom_range(0, 9) < 8,
                          4'($urandom_range(0, 15))));
    end
  endtask

  task automatic test_patterns(input int unsigned target);
    int r;
    while (beats_sent < target) begin
      r = $urandom_range(0, 9);
      if (r == 0)
        send_cmd(make_cmd(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          4'($urandom_range(0, 15))));
      else if (r < 5)
        run_pattern(4'($urandom_range(0, 12)), $urandom_range(5, 30));
      else
        run_pattern(4'($urandom_range(0, 12)), $urandom_range(60, 130));
    end
  endtask

  // sender holds off until every result is back
  task automatic test_drain_pause();
    for (int k = 0; k < 3; k++) begin
      run_pattern(4'($urandom_range(0, 12)), $urandom_range(3, 8));
      drop_cmd();
      wait_drained(20000);
    end
  endtask

  // back-to-back beats with no idling on either side
  task automatic test_quiet_stretch();
    quiet = 1'b1;
    run_pattern(ST_RESET_WARN, 40);
    quiet = 1'b0;
  endtask

  // main sequence
  initial begin
    rst        = 1'b1;
    cmd_valid  = 1'b0;
    cmd        = '0;
    quiet      = 1'b0;
    err_count  = 0;
    beats_sent = 0;
    pred_mode[0]  = MODE_OFF;
    pred_mode[1]  = MODE_OFF;
    pred_count[0] = '0;
    pred_count[1] = '0;
    pred_level[0] = 1'b0;
    pred_level[1] = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_drain_pause();
    test_patterns(250);
    test_quiet_stretch();
    test_patterns(410);

    drop_cmd();
    wait_drained(20000);
    repeat (10) @(posedge clk);
    while (levels_q.size() != 0) begin
      void'(levels_q.pop_front());
      report_mismatch("expected led beat never arrived");
    end
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== two_led_status_pattern_driver.f =====
hw/rtl/tlsp_pkg.sv
hw/rtl/tlsp_status_decode.sv
hw/rtl/tlsp_led_channel.sv
hw/rtl/two_led_status_pattern_driver.sv
tb/tb.sv
